FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define IPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define IPC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: src/svpwm_ipc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SVPWM inverse Park / compare package
// Shared constants, types and the sine ROM entry generator.
// ---------------------------------------------------------------------------
package svpwm_ipc_pkg;

  localparam int unsigned SINE_DEPTH_DEF = 1024;

  // angle constants in Q15
  localparam int TWO_PI_Q15  = 205887;
  localparam int HALF_TURN   = 102943;  // rounding offset for the ROM index
  localparam int HALF_PI_Q15 = 51472;
  localparam int ROOT3_Q15   = 56755;

  // reduction mod 2*pi: u = ang + 82*2pi keeps u positive
  localparam logic [25:0] ANG_BIAS  = 26'd16882734;
  localparam logic [14:0] RECIP_2PI = 15'd20860;  // floor(2^32 / 205887)
  localparam int          RECIP_SH  = 32;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;

  localparam int PERIOD_W  = 16;
  localparam int GAIN_W    = 31;
  localparam int CFG_IDX_W = 2;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd6000;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 31'd14188960;

  localparam int T_W        = 34;  // active time before overrun scaling
  localparam int SUM_W      = 35;
  localparam int FRAC_BITS  = 17;
  localparam int QUO_W      = 18;
  localparam int DIV_STAGES = 18;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PWM_PERIOD = 2'd0,
    CFG_TIME_GAIN  = 2'd1
  } cfg_reg_e;

  // bit0 vr1>0, bit1 vr2>0, bit2 vr3>0
  typedef enum logic [2:0] {
    SEC_NONE = 3'd0,
    SEC_R1   = 3'd1,
    SEC_R2   = 3'd2,
    SEC_R12  = 3'd3,
    SEC_R3   = 3'd4,
    SEC_R13  = 3'd5,
    SEC_R23  = 3'd6,
    SEC_ALL  = 3'd7
  } sector_e;

  // word handed from the front to the back through the queue
  typedef struct packed {
    logic [31:0] x1;
    logic [31:0] x2;
    sector_e     code;
  } work_t;

  // sideband riding along the divider
  typedef struct packed {
    sector_e     code;
    logic        ovr;
    logic [15:0] t1;
    logic [15:0] t2;
  } div_side_t;

  // one sine entry; x is the angle in Q30 radians over [0, 2*pi)
  function automatic logic signed [16:0] sine_entry(input longint x);
    longint v;
    longint x2;
    longint t;
    longint s;
    logic   neg;
    v   = x;
    neg = 1'b0;
    if (v > PI_Q30) v = v - TWO_PI_Q30;
    if (v < 0) begin
      neg = 1'b1;
      v   = -v;
    end
    if (v > HALF_PI_Q30) v = PI_Q30 - v;
    x2 = (v * v) >>> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >>> 30) / 110;
    t  = ONE_Q30 - ((x2 * t) >>> 30) / 72;
    t  = ONE_Q30 - ((x2 * t) >>> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >>> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >>> 30) / 6;
    s  = (v * t) >>> 30;
    s  = (s + 16384) >>> 15;
    return 17'(neg ? -s : s);
  endfunction

endpackage

FILE: src/svpwm_ipc_ifs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SVPWM inverse Park / compare channels
// Valid/ready command and result channels.
// ---------------------------------------------------------------------------
interface svpwm_ipc_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] volt_d;
  logic signed [31:0] volt_q;
  logic signed [31:0] elec_angle;

  modport source (output valid, volt_d, volt_q, elec_angle, input ready);
  modport sink   (input valid, volt_d, volt_q, elec_angle, output ready);
endinterface

interface svpwm_ipc_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] compare_a;
  logic [15:0] compare_b;
  logic [15:0] compare_c;
  logic [2:0]  sector_code;

  modport source (output valid, compare_a, compare_b, compare_c, sector_code, input ready);
  modport sink   (input valid, compare_a, compare_b, compare_c, sector_code, output ready);
endinterface

FILE: src/svpwm_inverse_park_compare_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SVPWM inverse Park and compare core
// Turns a d/q voltage command and angle into three PWM compare values.
// ---------------------------------------------------------------------------
// Usage:
//   cmd_i takes one word per cycle (volt_d, volt_q in Q15, elec_angle in Q22
//   radians) under valid/ready. res_o returns one word per command, in order:
//   compare_a/b/c in timer counts plus the 3-bit sector code.
//   cfg_we_i writes pwm_period (index 0) or time_gain (index 1) from
//   cfg_wdata_i; other indexes are dropped. Write only while idle.
// Timing:
//   Fully pipelined, one word per cycle sustained while res_o is ready. From
//   acceptance to res_o.valid a word passes 12 front stages, one
//   queue slot, then 24 back stages of which 18 are the bit-per-stage
//   overrun divider.
// Reset:
//   Clears all pipeline valids and the queue; period returns to 6000 and
//   gain to 14188960. The sine ROM is constant, so no clearing pass.
// Stall:
//   A stalled res_o freezes the back pipeline; the front keeps taking
//   commands until the 4-word queue and its own stages fill up.
// ---------------------------------------------------------------------------
module svpwm_inverse_park_compare_core #(
  parameter int unsigned SINE_TABLE_DEPTH = svpwm_ipc_pkg::SINE_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  svpwm_ipc_cmd_if.sink                         cmd_i,
  svpwm_ipc_res_if.source                       res_o,
  input  logic                                  cfg_we_i,
  input  logic [svpwm_ipc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [svpwm_ipc_pkg::GAIN_W-1:0]      cfg_wdata_i
);

  logic [svpwm_ipc_pkg::PERIOD_W-1:0] period_q;
  logic [svpwm_ipc_pkg::GAIN_W-1:0]   gain_q;

  logic                 push, full, q_valid, pop;
  svpwm_ipc_pkg::work_t push_data, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= svpwm_ipc_pkg::PERIOD_RST;
      gain_q   <= svpwm_ipc_pkg::GAIN_RST;
    end else if (cfg_we_i) begin
      case (svpwm_ipc_pkg::cfg_reg_e'(cfg_idx_i))
        svpwm_ipc_pkg::CFG_PWM_PERIOD: period_q <= cfg_wdata_i[svpwm_ipc_pkg::PERIOD_W-1:0];
        svpwm_ipc_pkg::CFG_TIME_GAIN:  gain_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  svpwm_ipc_front #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  svpwm_ipc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  svpwm_ipc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_head),
    .pop_o        (pop),
    .pwm_period_i (period_q),
    .time_gain_i  (gain_q),
    .res_o        (res_o)
  );

endmodule

FILE: src/svpwm_ipc_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SVPWM front pipeline
// Angle reduction, sine ROM, inverse Park, references and sector select.
// ---------------------------------------------------------------------------
module svpwm_ipc_front #(
  parameter int unsigned SINE_TABLE_DEPTH = svpwm_ipc_pkg::SINE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  svpwm_ipc_cmd_if.sink         cmd_i,
  input  logic                  full_i,
  output logic                  push_o,
  output svpwm_ipc_pkg::work_t  push_data_o
);

  localparam int NF   = 12;
  localparam int IW   = $clog2(SINE_TABLE_DEPTH);
  localparam int NS_W = $clog2(svpwm_ipc_pkg::TWO_PI_Q15 * SINE_TABLE_DEPTH) + 1;
  localparam int PW   = NS_W + 15;

  logic [NF-1:0] vld_q;
  logic          en;

  // constant sine ROM
  logic signed [16:0] rom_w [SINE_TABLE_DEPTH];
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam longint XK = longint'(k) * svpwm_ipc_pkg::TWO_PI_Q30 /
                            longint'(SINE_TABLE_DEPTH);
    assign rom_w[k] = svpwm_ipc_pkg::sine_entry(XK);
  end

  // stage registers
  logic        [25:0]   u0_q, u1_q;
  logic        [7:0]    qe1_q;
  logic        [17:0]   r2_q, rc2_q;
  logic        [NS_W-1:0] ns3_q, nc3_q, ns4_q, nc4_q;
  logic        [IW:0]   qs4_q, qc4_q;
  logic        [IW-1:0] is5_q, ic5_q;
  logic signed [16:0]   sn6_q, cs6_q;
  logic signed [31:0]   vd_q [7];
  logic signed [31:0]   vq_q [7];
  logic signed [31:0]   pdc_q, pqs_q, pds_q, pqc_q;
  logic signed [31:0]   va8_q, vb8_q, m9_q, vb9_q;
  logic signed [31:0]   vr1_q, vr2_q, vr3_q;
  svpwm_ipc_pkg::work_t work_q;

  // combinational values
  logic signed [24:0]   ang;
  logic        [25:0]   u_d;
  logic        [40:0]   pq1;
  logic        [25:0]   diff2;
  logic        [18:0]   r0, rcs;
  logic        [17:0]   r_d, rc_d;
  logic        [PW-1:0] ps4, pc4;
  logic        [NS_W-1:0] rems, remc;
  logic        [IW:0]   qs5, qc5;
  logic signed [48:0]   mdc, mqs, mds, mqc, m9;
  logic signed [31:0]   d2, d3;
  logic        [2:0]    sgn;
  svpwm_ipc_pkg::work_t work_d;

  assign en           = !(vld_q[NF-1] && full_i);
  assign cmd_i.ready  = en;
  assign push_o       = vld_q[NF-1] && !full_i;
  assign push_data_o  = work_q;

  always_comb begin
    ang   = 25'(cmd_i.elec_angle >>> 7);
    u_d   = 26'(ang) + svpwm_ipc_pkg::ANG_BIAS;
    pq1   = 41'(u0_q) * 41'(svpwm_ipc_pkg::RECIP_2PI);

    diff2 = u1_q - 26'(qe1_q) * 26'(svpwm_ipc_pkg::TWO_PI_Q15);
    r0    = diff2[18:0];
    r_d   = (r0 >= 19'(svpwm_ipc_pkg::TWO_PI_Q15)) ?
            18'(r0 - 19'(svpwm_ipc_pkg::TWO_PI_Q15)) : r0[17:0];
    rcs   = 19'(r_d) + 19'(svpwm_ipc_pkg::HALF_PI_Q15);
    rc_d  = (rcs >= 19'(svpwm_ipc_pkg::TWO_PI_Q15)) ?
            18'(rcs - 19'(svpwm_ipc_pkg::TWO_PI_Q15)) : rcs[17:0];

    ps4   = PW'(ns3_q) * PW'(svpwm_ipc_pkg::RECIP_2PI);
    pc4   = PW'(nc3_q) * PW'(svpwm_ipc_pkg::RECIP_2PI);

    // one correction step after the reciprocal estimate, then wrap at the top
    rems  = ns4_q - NS_W'(qs4_q) * NS_W'(svpwm_ipc_pkg::TWO_PI_Q15);
    remc  = nc4_q - NS_W'(qc4_q) * NS_W'(svpwm_ipc_pkg::TWO_PI_Q15);
    qs5   = qs4_q + (IW+1)'(rems >= NS_W'(svpwm_ipc_pkg::TWO_PI_Q15));
    qc5   = qc4_q + (IW+1)'(remc >= NS_W'(svpwm_ipc_pkg::TWO_PI_Q15));

    mdc   = vd_q[6] * cs6_q;
    mqs   = vq_q[6] * sn6_q;
    mds   = vd_q[6] * sn6_q;
    mqc   = vq_q[6] * cs6_q;
    m9    = 17'sd56755 * va8_q;

    d2    = m9_q - vb9_q;
    d3    = 32'sd0 - vb9_q - m9_q;

    sgn         = {vr3_q > 0, vr2_q > 0, vr1_q > 0};
    work_d.code = svpwm_ipc_pkg::sector_e'(sgn);
    work_d.x1   = '0;
    work_d.x2   = '0;
    case (work_d.code)
      svpwm_ipc_pkg::SEC_R12: begin
        work_d.x1 = vr2_q;
        work_d.x2 = vr1_q;
      end
      svpwm_ipc_pkg::SEC_R1: begin
        work_d.x1 = 32'd0 - vr2_q;
        work_d.x2 = 32'd0 - vr3_q;
      end
      svpwm_ipc_pkg::SEC_R13: begin
        work_d.x1 = vr1_q;
        work_d.x2 = vr3_q;
      end
      svpwm_ipc_pkg::SEC_R3: begin
        work_d.x1 = 32'd0 - vr1_q;
        work_d.x2 = 32'd0 - vr2_q;
      end
      svpwm_ipc_pkg::SEC_R23: begin
        work_d.x1 = vr3_q;
        work_d.x2 = vr2_q;
      end
      svpwm_ipc_pkg::SEC_R2: begin
        work_d.x1 = 32'd0 - vr3_q;
        work_d.x2 = 32'd0 - vr1_q;
      end
      default: begin
        work_d.x1 = '0;
        work_d.x2 = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NF-2:0], cmd_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u0_q     <= u_d;
      vd_q[0]  <= cmd_i.volt_d;
      vq_q[0]  <= cmd_i.volt_q;
      for (int i = 1; i < 7; i++) begin
        vd_q[i] <= vd_q[i-1];
        vq_q[i] <= vq_q[i-1];
      end
      u1_q     <= u0_q;
      qe1_q    <= 8'(pq1 >> svpwm_ipc_pkg::RECIP_SH);
      r2_q     <= r_d;
      rc2_q    <= rc_d;
      ns3_q    <= NS_W'(r2_q) * NS_W'(SINE_TABLE_DEPTH) + NS_W'(svpwm_ipc_pkg::HALF_TURN);
      nc3_q    <= NS_W'(rc2_q) * NS_W'(SINE_TABLE_DEPTH) + NS_W'(svpwm_ipc_pkg::HALF_TURN);
      ns4_q    <= ns3_q;
      nc4_q    <= nc3_q;
      qs4_q    <= (IW+1)'(ps4 >> svpwm_ipc_pkg::RECIP_SH);
      qc4_q    <= (IW+1)'(pc4 >> svpwm_ipc_pkg::RECIP_SH);
      is5_q    <= (qs5 >= (IW+1)'(SINE_TABLE_DEPTH)) ? '0 : qs5[IW-1:0];
      ic5_q    <= (qc5 >= (IW+1)'(SINE_TABLE_DEPTH)) ? '0 : qc5[IW-1:0];
      sn6_q    <= rom_w[is5_q];
      cs6_q    <= rom_w[ic5_q];
      pdc_q    <= mdc[46:15];
      pqs_q    <= mqs[46:15];
      pds_q    <= mds[46:15];
      pqc_q    <= mqc[46:15];
      va8_q    <= pdc_q - pqs_q;
      vb8_q    <= pds_q + pqc_q;
      m9_q     <= m9[46:15];
      vb9_q    <= vb8_q;
      vr1_q    <= vb9_q;
      vr2_q    <= d2 >>> 1;
      vr3_q    <= d3 >>> 1;
      work_q   <= work_d;
    end
  end

endmodule

FILE: src/svpwm_ipc_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SVPWM work queue
// Short FIFO between the front and back pipelines.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module svpwm_ipc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  svpwm_ipc_pkg::work_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output svpwm_ipc_pkg::work_t head_o
);

  localparam int DEPTH = svpwm_ipc_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;

  svpwm_ipc_pkg::work_t mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  `IPC_NEVER(a_push_full, push_i && (cnt_q == CW'(DEPTH)), "push into full queue")
  `IPC_NEVER(a_pop_empty, pop_i && (cnt_q == '0), "pop from empty queue")
  `IPC_ASSERT(a_cnt_up, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1), "count lost a word")

endmodule

FILE: src/svpwm_ipc_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SVPWM overrun divider
// Pipelined restoring divide of num*2^17 by den, one quotient bit a stage.
// ---------------------------------------------------------------------------
module svpwm_ipc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [svpwm_ipc_pkg::T_W-1:0]     num_i,
  input  logic [svpwm_ipc_pkg::SUM_W-1:0]   den_i,
  input  svpwm_ipc_pkg::div_side_t          side_i,
  output logic                              valid_o,
  output logic [svpwm_ipc_pkg::QUO_W-1:0]   quo_o,
  output logic                              rem_nz_o,
  output svpwm_ipc_pkg::div_side_t          side_o
);

  localparam int NS = svpwm_ipc_pkg::DIV_STAGES;
  localparam int DW = svpwm_ipc_pkg::SUM_W;
  localparam int QW = svpwm_ipc_pkg::QUO_W;

  logic                      vld_q  [NS];
  logic [DW-1:0]             rem_q  [NS];
  logic [DW-1:0]             den_q  [NS];
  logic [QW-1:0]             quo_q  [NS];
  svpwm_ipc_pkg::div_side_t  side_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW:0]    rin;
    logic [DW-1:0]  den_in;
    logic [QW-1:0]  quo_in;
    logic           ge;
    svpwm_ipc_pkg::div_side_t side_in;
    logic           vld_in;

    if (s == 0) begin : g_first
      // num <= den, so the top quotient bit compares without a shift
      assign rin     = (DW+1)'(num_i);
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rin     = {rem_q[s-1], 1'b0};
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    assign ge = (rin >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? DW'(rin - {1'b0, den_in}) : DW'(rin);
        den_q[s]  <= den_in;
        quo_q[s]  <= {quo_in[QW-2:0], ge};
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o  = vld_q[NS-1];
  assign quo_o    = quo_q[NS-1];
  assign rem_nz_o = (rem_q[NS-1] != '0);
  assign side_o   = side_q[NS-1];

endmodule

FILE: src/svpwm_ipc_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SVPWM back pipeline
// Active times, overrun scaling and sector-mapped compare values.
// ---------------------------------------------------------------------------
module svpwm_ipc_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_valid_i,
  input  svpwm_ipc_pkg::work_t                  q_data_i,
  output logic                                  pop_o,
  input  logic [svpwm_ipc_pkg::PERIOD_W-1:0]    pwm_period_i,
  input  logic [svpwm_ipc_pkg::GAIN_W-1:0]      time_gain_i,
  svpwm_ipc_res_if.source                       res_o
);

  localparam int TW = svpwm_ipc_pkg::T_W;
  localparam int SW = svpwm_ipc_pkg::SUM_W;
  localparam int QW = svpwm_ipc_pkg::QUO_W;
  localparam int FB = svpwm_ipc_pkg::FRAC_BITS;

  logic en;
  logic [2:0] pre_vld_q;
  logic [2:0] post_vld_q;

  svpwm_ipc_pkg::work_t      w0_q;
  logic [TW-1:0]             t1_1_q, t2_1_q, t1_2_q;
  svpwm_ipc_pkg::sector_e    code1_q;
  logic [SW-1:0]             sum2_q;
  svpwm_ipc_pkg::div_side_t  side2_q, side_d;

  logic                      div_vld;
  logic [QW-1:0]             div_quo;
  logic                      div_rem_nz;
  svpwm_ipc_pkg::div_side_t  div_side;

  logic [QW-1:0]             q1_q, q2_q;
  svpwm_ipc_pkg::div_side_t  side3_q;
  logic [15:0]               t1f_q, t2f_q;
  svpwm_ipc_pkg::sector_e    code4_q;
  logic [15:0]               ca_q, cb_q, cc_q;
  svpwm_ipc_pkg::sector_e    code5_q;

  logic [63:0]               p1, p2;
  logic [SW-1:0]             sum_d;
  logic [TW-1:0]             pr1, pr2;
  logic [16:0]               s12;
  logic [15:0]               ta, tb, tc, ca_d, cb_d, cc_d;

  assign en    = !post_vld_q[2] || res_o.ready;
  assign pop_o = en && q_valid_i;

  always_comb begin
    p1    = 64'(w0_q.x1) * 64'(time_gain_i);
    p2    = 64'(w0_q.x2) * 64'(time_gain_i);
    sum_d = SW'(t1_1_q) + SW'(t2_1_q);

    side_d.code = code1_q;
    side_d.ovr  = (sum_d > SW'(pwm_period_i));
    side_d.t1   = t1_1_q[15:0];
    side_d.t2   = t2_1_q[15:0];

    pr1 = TW'(q1_q) * TW'(pwm_period_i);
    pr2 = TW'(q2_q) * TW'(pwm_period_i);

    s12 = 17'(t1f_q) + 17'(t2f_q);
    ta  = 16'((17'(pwm_period_i) - s12) >> 1);
    tb  = 16'((18'(pwm_period_i) + 18'(t1f_q) - 18'(t2f_q)) >> 1);
    tc  = 16'((18'(pwm_period_i) + 18'(s12)) >> 1);

    case (code4_q)
      svpwm_ipc_pkg::SEC_R12: begin ca_d = ta; cb_d = tb; cc_d = tc; end
      svpwm_ipc_pkg::SEC_R1:  begin ca_d = tb; cb_d = ta; cc_d = tc; end
      svpwm_ipc_pkg::SEC_R13: begin ca_d = tc; cb_d = ta; cc_d = tb; end
      svpwm_ipc_pkg::SEC_R3:  begin ca_d = tc; cb_d = tb; cc_d = ta; end
      svpwm_ipc_pkg::SEC_R23: begin ca_d = tb; cb_d = tc; cc_d = ta; end
      svpwm_ipc_pkg::SEC_R2:  begin ca_d = ta; cb_d = tc; cc_d = tb; end
      default: begin
        ca_d = pwm_period_i;
        cb_d = pwm_period_i;
        cc_d = pwm_period_i;
      end
    endcase
  end

  svpwm_ipc_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (pre_vld_q[2]),
    .num_i    (t1_2_q),
    .den_i    (sum2_q),
    .side_i   (side2_q),
    .valid_o  (div_vld),
    .quo_o    (div_quo),
    .rem_nz_o (div_rem_nz),
    .side_o   (div_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q  <= '0;
      post_vld_q <= '0;
    end else if (en) begin
      pre_vld_q  <= {pre_vld_q[1:0], q_valid_i};
      post_vld_q <= {post_vld_q[1:0], div_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w0_q    <= q_data_i;
      t1_1_q  <= TW'((p1 + 64'd16384) >> 30);
      t2_1_q  <= TW'((p2 + 64'd16384) >> 30);
      code1_q <= w0_q.code;
      t1_2_q  <= t1_1_q;
      sum2_q  <= sum_d;
      side2_q <= side_d;
      // second ratio follows from the first quotient and its remainder
      q1_q    <= div_quo;
      q2_q    <= QW'(1 << FB) - div_quo - QW'(div_rem_nz);
      side3_q <= div_side;
      t1f_q   <= side3_q.ovr ? 16'(pr1 >> FB) : side3_q.t1;
      t2f_q   <= side3_q.ovr ? 16'(pr2 >> FB) : side3_q.t2;
      code4_q <= side3_q.code;
      ca_q    <= ca_d;
      cb_q    <= cb_d;
      cc_q    <= cc_d;
      code5_q <= code4_q;
    end
  end

  assign res_o.valid       = post_vld_q[2];
  assign res_o.compare_a   = ca_q;
  assign res_o.compare_b   = cb_q;
  assign res_o.compare_c   = cc_q;
  assign res_o.sector_code = code5_q;

endmodule
